FILE: rtl/rau_pkg.sv
`default_nettype none
package rau_pkg;
  localparam int OperandWidthDef = 16;
  localparam int ResNumWidth = 33;
  localparam int ResDenWidth = 32;

  typedef enum logic [1:0] {
    FUNC_ADD = 2'd0,
    FUNC_SUB = 2'd1,
    FUNC_MUL = 2'd2,
    FUNC_DIV = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUM,
    ST_GCD,
    ST_DIVN,
    ST_DIVD,
    ST_OUT
  } be_state_t;
endpackage
`default_nettype wire

FILE: rtl/rau_front.sv
`default_nettype none
// Substitute zero denominators, flag; two-entry queue to the back end.
module rau_front import rau_pkg::*; #(
  parameter int OperandWidth = OperandWidthDef
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [1:0]              in_func,
  input  wire logic [OperandWidth-1:0] in_a_num,
  input  wire logic [OperandWidth-1:0] in_a_den,
  input  wire logic [OperandWidth-1:0] in_b_num,
  input  wire logic [OperandWidth-1:0] in_b_den,
  output logic                         q_valid,
  input  wire logic                    q_ready,
  output logic [1:0]                   q_func,
  output logic [OperandWidth-1:0]      q_a_num,
  output logic [OperandWidth-1:0]      q_a_den,
  output logic [OperandWidth-1:0]      q_b_num,
  output logic [OperandWidth-1:0]      q_b_den,
  output logic                         q_den_zero,
  output logic                         q_div_zero
);
  localparam int EW = 2 + 4 * OperandWidth + 2;
  logic [EW-1:0] mem [2];
  logic          wr_ptr, rd_ptr;
  logic [1:0]    count;
  logic [EW-1:0] entry, head;
  logic [OperandWidth-1:0] ad, bd;
  logic          dz, vz;
  logic          push, pop;

  always_comb begin
    dz = 1'b0;
    ad = in_a_den;
    bd = in_b_den;
    if (in_a_den == '0) begin
      ad = OperandWidth'(1);
      dz = 1'b1;
    end
    if (in_b_den == '0) begin
      bd = OperandWidth'(1);
      dz = 1'b1;
    end
    vz = (in_func == FUNC_DIV) && (in_b_num == '0);
    entry = {in_func, in_a_num, ad, in_b_num, bd, dz, vz};
  end

  assign in_ready = (count != 2'd2);
  assign q_valid  = (count != 2'd0);
  assign push = in_valid && in_ready;
  assign pop  = q_valid && q_ready;
  assign head = mem[rd_ptr];
  assign {q_func, q_a_num, q_a_den, q_b_num, q_b_den, q_den_zero, q_div_zero} = head;

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

FILE: rtl/rau_back.sv
`default_nettype none
// Cross products, binary gcd, restoring divisions by the gcd, sign fix-up.
module rau_back import rau_pkg::*; #(
  parameter int OperandWidth = OperandWidthDef
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    q_valid,
  output logic                         q_ready,
  input  wire logic [1:0]              q_func,
  input  wire logic [OperandWidth-1:0] q_a_num,
  input  wire logic [OperandWidth-1:0] q_a_den,
  input  wire logic [OperandWidth-1:0] q_b_num,
  input  wire logic [OperandWidth-1:0] q_b_den,
  input  wire logic                    q_den_zero,
  input  wire logic                    q_div_zero,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [ResNumWidth-1:0]       res_num,
  output logic [ResDenWidth-1:0]       res_den,
  output logic                         operand_den_zero,
  output logic                         divide_by_zero
);
  localparam int PW = 2 * OperandWidth;     // product width
  localparam int MW = PW + 1;               // magnitude width of sums
  localparam int CW = $clog2(MW + 1);

  be_state_t state, state_next;
  logic [1:0]              func;
  logic signed [OperandWidth-1:0] an, ad, bn, bd;
  logic                    dzf, vzf;
  logic signed [PW-1:0]    p0, p1, p2;
  logic                    neg;
  logic [MW-1:0]           mn, md, gx, gy, g;
  logic [CW-1:0]           shift;
  logic [MW-1:0]           quo, rem, dvd;
  logic [CW-1:0]           bit_cnt;
  logic [MW-1:0]           qn;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (q_valid) state_next = ST_MUL;
      ST_MUL:  state_next = ST_SUM;
      ST_SUM:  state_next = ST_GCD;
      ST_GCD:  if (gy == '0) state_next = ST_DIVN;
      ST_DIVN: if (bit_cnt == '0) state_next = ST_DIVD;
      ST_DIVD: if (bit_cnt == '0) state_next = ST_OUT;
      ST_OUT:  if (out_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    q_ready   = (state == ST_IDLE);
    out_valid = (state == ST_OUT);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  logic [MW:0] trial;
  always_comb trial = {rem[MW-1:0], dvd[MW-1]} - {1'b0, g};

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: if (q_valid) begin
        func <= q_func;
        an <= q_a_num; ad <= q_a_den; bn <= q_b_num; bd <= q_b_den;
        dzf <= q_den_zero; vzf <= q_div_zero;
      end
      ST_MUL: begin
        if (vzf) begin
          p0 <= PW'(an); p1 <= '0; p2 <= PW'(ad);
        end else begin
          unique case (func_t'(func))
            FUNC_ADD, FUNC_SUB: begin p0 <= an * bd; p1 <= bn * ad; p2 <= ad * bd; end
            FUNC_MUL: begin p0 <= an * bn; p1 <= '0; p2 <= ad * bd; end
            default:  begin p0 <= an * bd; p1 <= '0; p2 <= ad * bn; end
          endcase
        end
      end
      ST_SUM: begin : sum_blk
        logic signed [MW-1:0] n;
        n = (func == FUNC_SUB && !vzf) ? MW'(p0) - MW'(p1) : MW'(p0) + MW'(p1);
        mn  <= n[MW-1] ? -n : n;
        md  <= p2[PW-1] ? MW'(-p2) : MW'(p2);
        gx  <= n[MW-1] ? -n : n;
        gy  <= p2[PW-1] ? MW'(-p2) : MW'(p2);
        neg <= (n[MW-1] != p2[PW-1]) && (n != '0);
        shift <= '0;
      end
      ST_GCD: begin
        // binary gcd, one step a cycle; denominator is never zero
        if (gx == '0) begin
          gx <= gy; gy <= '0;
        end else if (gy != '0) begin
          if (!gx[0] && !gy[0]) begin
            gx <= gx >> 1; gy <= gy >> 1; shift <= shift + 1'b1;
          end else if (!gx[0]) gx <= gx >> 1;
          else if (!gy[0]) gy <= gy >> 1;
          else if (gx >= gy) gx <= (gx - gy) >> 1;
          else gy <= (gy - gx) >> 1;
        end
        if (gy == '0 || gx == '0) begin
          dvd <= mn; rem <= '0; bit_cnt <= CW'(MW - 1);
        end
        if (gy == '0) g <= gx << shift;
        else if (gx == '0) g <= gy << shift;
      end
      ST_DIVN, ST_DIVD: begin
        if (bit_cnt == '0 && state == ST_DIVN) begin
          qn <= {dvd[MW-2:0], !trial[MW]};
          dvd <= md; rem <= '0; bit_cnt <= CW'(MW - 1);
        end else begin
          if (!trial[MW]) begin
            rem <= trial[MW-1:0];
            dvd <= {dvd[MW-2:0], 1'b1};
          end else begin
            rem <= {rem[MW-2:0], dvd[MW-1]};
            dvd <= {dvd[MW-2:0], 1'b0};
          end
          if (bit_cnt == '0) quo <= {dvd[MW-2:0], !trial[MW]};
          else bit_cnt <= bit_cnt - 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    res_num = neg ? ResNumWidth'(-qn) : ResNumWidth'(qn);
    res_den = vzf ? ResDenWidth'(1) : ResDenWidth'(quo);
    operand_den_zero = dzf;
    divide_by_zero   = vzf;
  end
endmodule
`default_nettype wire

FILE: rtl/rational_arithmetic_unit.sv
// Rational arithmetic unit: a_num/a_den op b_num/b_den, result reduced.
// Input channel: in_valid/in_ready with func (0 add, 1 sub, 2 mul, 3 div)
// and four OPERAND_WIDTH-bit signed operands. Output channel:
// out_valid/out_ready with res_num (signed), res_den (>= 1) and two flags.
// A zero operand denominator is taken as 1 and flagged; divide by a zero
// fraction returns a's reduced numerator over 1 and is flagged.
// Per request: a wait in the queue, set-up (capture, cross products, sum
// and magnitudes), a binary gcd loop, then two restoring divisions by the
// gcd (numerator first, then denominator), then the output state. The gcd
// loop and the shared divider set the rate; one request is worked on at a
// time.
// A two-entry queue in front takes new requests while the back end works.
// When the receiver stalls the result holds on the output and the back end
// waits; the queue keeps accepting until full.
// Reset (rst, synchronous) empties the queue and idles the back end.
`default_nettype none
module rational_arithmetic_unit import rau_pkg::*; #(
  parameter int OPERAND_WIDTH = OperandWidthDef
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [1:0]               func,
  input  wire logic [OPERAND_WIDTH-1:0] a_num,
  input  wire logic [OPERAND_WIDTH-1:0] a_den,
  input  wire logic [OPERAND_WIDTH-1:0] b_num,
  input  wire logic [OPERAND_WIDTH-1:0] b_den,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic [ResNumWidth-1:0]        res_num,
  output logic [ResDenWidth-1:0]        res_den,
  output logic                          operand_den_zero,
  output logic                          divide_by_zero
);
  logic q_valid, q_ready, q_dz, q_vz;
  logic [1:0] q_func;
  logic [OPERAND_WIDTH-1:0] q_an, q_ad, q_bn, q_bd;

  rau_front #(.OperandWidth(OPERAND_WIDTH)) u_front (
    .clk, .rst, .in_valid, .in_ready,
    .in_func(func), .in_a_num(a_num), .in_a_den(a_den),
    .in_b_num(b_num), .in_b_den(b_den),
    .q_valid, .q_ready, .q_func, .q_a_num(q_an), .q_a_den(q_ad),
    .q_b_num(q_bn), .q_b_den(q_bd), .q_den_zero(q_dz), .q_div_zero(q_vz)
  );

  rau_back #(.OperandWidth(OPERAND_WIDTH)) u_back (
    .clk, .rst, .q_valid, .q_ready, .q_func, .q_a_num(q_an), .q_a_den(q_ad),
    .q_b_num(q_bn), .q_b_den(q_bd), .q_den_zero(q_dz), .q_div_zero(q_vz),
    .out_valid, .out_ready, .res_num, .res_den, .operand_den_zero,
    .divide_by_zero
  );
endmodule
`default_nettype wire
